### rtl/assert_macros.svh
// Assertion macros for the RTL files; the list core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that implies another at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A condition that implies another at the following edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/alc_pkg.sv
package alc_pkg;

  // Number of cells whose read outputs are combined in the first level of the read tree.
  localparam int RD_GROUP = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIRST  = 2'd1,
    OP_NEXT   = 2'd2,
    OP_REMOVE = 2'd3
  } alc_op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } alc_status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RD1  = 2'd1,
    S_RD2  = 2'd2,
    S_UPD  = 2'd3
  } alc_state_t;

  typedef struct packed {
    alc_op_t            op;
    logic signed [31:0] data_in;
  } alc_in_t;

  typedef struct packed {
    alc_status_t        status;
    logic signed [31:0] data_out;
    logic [7:0]         entry_count;
  } alc_out_t;

  typedef struct packed {
    logic wr;
    logic sh;
    logic rd;
  } alc_cell_ctrl_t;

endpackage

### rtl/alc_cell.sv
module alc_cell
  import alc_pkg::*;
(
  input  logic               clk,
  input  alc_cell_ctrl_t     ctrl,
  input  logic signed [31:0] din,
  input  logic signed [31:0] nbr_word,
  output logic signed [31:0] word,
  output logic signed [31:0] rd_word
);

  logic signed [31:0] word_r;

  // A write appends at the end of the list; a shift pulls the upper neighbor down.
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      word_r <= din;
    end else if (ctrl.sh) begin
      word_r <= nbr_word;
    end
  end

  assign word    = word_r;
  assign rd_word = ctrl.rd ? word_r : '0;

endmodule

### rtl/array_list_with_cursor_core.sv
// Ordered list of signed 32-bit words with a cursor, held in a row of CAPACITY cells.
// A transaction is accepted in the idle state, then passes the registered OR tree that
// reads a word out of the cell row (groups of 16 cells, then across the groups), and
// then the update state, which changes the list and loads the result register. A new
// transaction is accepted only in the idle state, after the previous one has updated;
// a result that is not taken holds the update stage until out_ready rises. Remove
// shifts all later cells down at once, since each cell loads from its upper neighbor.
`include "assert_macros.svh"

module array_list_with_cursor_core
  import alc_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  alc_in_t  in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output alc_out_t out_item
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int NGRP  = (CAPACITY + RD_GROUP - 1) / RD_GROUP;
  localparam int NPAD  = NGRP * RD_GROUP;

  alc_state_t         state_r, state_nxt;
  alc_op_t            op_r;
  logic signed [31:0] din_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  // Cursor plus one: zero stands for the position before the first entry.
  logic [CNT_W-1:0]   cp_r, cp_nxt;
  logic               out_valid_r, out_valid_nxt;
  alc_out_t           out_r, out_nxt;

  logic signed [31:0] grp_r [NGRP];
  logic signed [31:0] grp_nxt [NGRP];
  logic signed [31:0] rd_word_r, rd_word_nxt;

  logic signed [31:0] cell_word [CAPACITY];
  logic signed [31:0] masked [NPAD];

  logic [IDX_W-1:0]   rd_idx;
  alc_status_t        status;
  logic               full;
  logic               upd_go;
  logic               ins_do;
  logic               rem_do;
  logic               in_acc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    case (op_r)
      OP_FIRST:  rd_idx = '0;
      OP_NEXT:   rd_idx = IDX_W'(cp_r);
      OP_REMOVE: rd_idx = IDX_W'(cp_r - 1'b1);
      default:   rd_idx = '0;
    endcase
  end

  always_comb begin
    case (op_r)
      OP_INSERT: status = full ? ST_FULL : ST_OK;
      OP_FIRST:  status = (count_r == '0) ? ST_NONE : ST_OK;
      OP_NEXT:   status = (cp_r >= count_r) ? ST_NONE : ST_OK;
      OP_REMOVE: status = ((cp_r == '0) || (cp_r > count_r)) ? ST_NONE : ST_OK;
      default:   status = ST_NONE;
    endcase
  end

  assign ins_do = upd_go && (op_r == OP_INSERT) && (status == ST_OK);
  assign rem_do = upd_go && (op_r == OP_REMOVE) && (status == ST_OK);

  for (genvar i = 0; i < NPAD; i++) begin : g_cell
    if (i < CAPACITY) begin : g_live
      alc_cell_ctrl_t     ctrl;
      logic signed [31:0] nbr;

      assign ctrl.wr = ins_do && (count_r == CNT_W'(i));
      assign ctrl.sh = rem_do && (cp_r <= CNT_W'(i + 1));
      assign ctrl.rd = (rd_idx == IDX_W'(i));

      if (i + 1 < CAPACITY) begin : g_nbr
        assign nbr = cell_word[i + 1];
      end else begin : g_last
        assign nbr = '0;
      end

      alc_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .din      (din_r),
        .nbr_word (nbr),
        .word     (cell_word[i]),
        .rd_word  (masked[i])
      );
    end else begin : g_pad
      assign masked[i] = '0;
    end
  end

  // First level of the read tree: one OR over each group of cells.
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_comb begin
      grp_nxt[g] = '0;
      for (int j = 0; j < RD_GROUP; j++) begin
        grp_nxt[g] = grp_nxt[g] | masked[g * RD_GROUP + j];
      end
    end
  end

  always_comb begin
    rd_word_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_word_nxt = rd_word_nxt | grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    grp_r     <= grp_nxt;
    rd_word_r <= rd_word_nxt;
    out_r     <= out_nxt;
    if (in_acc) begin
      op_r  <= in_item.op;
      din_r <= in_item.data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cp_r        <= cp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cp_nxt        = cp_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    upd_go        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        state_nxt = S_RD2;
      end
      S_RD2: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        // The result register must be free before the list changes.
        if (!out_valid_r || out_ready) begin
          upd_go        = 1'b1;
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (status == ST_OK) begin
            case (op_r)
              OP_INSERT: count_nxt = count_r + 1'b1;
              OP_FIRST:  cp_nxt = CNT_W'(1);
              OP_NEXT:   cp_nxt = cp_r + 1'b1;
              OP_REMOVE: begin
                count_nxt = count_r - 1'b1;
                cp_nxt    = cp_r - 1'b1;
              end
              default:   count_nxt = count_r;
            endcase
          end
          out_nxt.status      = status;
          out_nxt.data_out    = ((status == ST_OK) && (op_r != OP_INSERT)) ? rd_word_r : '0;
          out_nxt.entry_count = 8'(count_nxt);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `ASSERT_HOLDS(a_count_cap, clk, rst_n, count_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `ASSERT_HOLDS(a_cursor_in_list, clk, rst_n, cp_r <= count_r, "cursor beyond the stored entries")
  `ASSERT_IMPLIES(a_fail_zero, clk, rst_n, out_valid && (out_item.status != ST_OK), out_item.data_out == '0, "failed transaction returns nonzero data")
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready && $stable(count_r), "new transaction taken while busy")

endmodule
